>>> rtl/core/viterbi_path_decoder_macros.svh
// Assertion macros for the Viterbi path decoder top level.
`ifndef VITERBI_PATH_DECODER_MACROS_SVH
`define VITERBI_PATH_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpd check failed");

// Next-cycle implication, checked outside reset.
`define VPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpd check failed");

`endif

>>> rtl/core/vpd_pkg.sv
// Types and constants shared by the Viterbi path decoder modules.
package vpd_pkg;

    localparam int FIELD_STATES = 16;
    localparam logic [4:0] NUM_STATES_RESET = 5'd16;
    localparam logic signed [31:0] INIT_PRIOR_RESET = -32'sd181704;

    localparam logic CFG_NUM_STATES = 1'b0;
    localparam logic CFG_INIT_PRIOR = 1'b1;

    localparam logic CMD_TRANSITION = 1'b0;
    localparam logic CMD_LIKELIHOOD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRSCAN,
        ST_CLOSE,
        ST_CHECK,
        ST_ARGMAX,
        ST_SEED,
        ST_EMIT,
        ST_WAIT,
        ST_BTREAD
    } vpd_state_t;

    typedef struct packed {
        logic take;
        logic trans_wr;
        logic k_clr;
        logic scan_issue;
        logic wr_first;
        logic wr_scan;
        logic close;
        logic set_ovf;
        logic am_step;
        logic seed;
        logic emit;
        logic bt_next;
        logic run_clear;
    } vpd_cmd_t;

    typedef struct packed {
        logic is_trans;
        logic in_range;
        logic frames_full;
        logic first_frame;
        logic k_last;
        logic decode_go;
        logic out_full;
        logic f_zero;
    } vpd_status_t;

endpackage

>>> rtl/core/vpd_ctrl.sv
// Sequencer for the Viterbi path decoder: request intake, scan, decode, backtrack.
module vpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vpd_pkg::vpd_status_t sts,
    output vpd_pkg::vpd_cmd_t    cmd
);
    import vpd_pkg::*;

    vpd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.k_clr = 1'b1;
                priority if (sts.is_trans)
                begin
                    cmd.trans_wr = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!sts.in_range)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.frames_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next = ST_CHECK;
                end
                else if (sts.first_frame)
                begin
                    cmd.wr_first = 1'b1;
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRSCAN;
            end
            ST_WRSCAN:
            begin
                cmd.wr_scan = 1'b1;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.close = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.k_clr = 1'b1;
                state_next = sts.decode_go ? ST_ARGMAX : ST_IDLE;
            end
            ST_ARGMAX:
            begin
                cmd.am_step = 1'b1;
                if (sts.k_last)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!sts.out_full)
                begin
                    if (sts.f_zero)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BTREAD;
                    end
                end
            end
            ST_BTREAD:
            begin
                cmd.bt_next = 1'b1;
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/vpd_datapath.sv
// Datapath: transition table, score banks, backpointer memory and result register.
module vpd_datapath #(
    parameter int MAX_STATES  = 16,
    parameter int MAX_FRAMES  = 64,
    parameter int SCORE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vpd_pkg::vpd_cmd_t    cmd,
    output vpd_pkg::vpd_status_t sts,
    input  logic                 cfg_wr,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 command,
    input  logic [3:0]           source_state,
    input  logic [3:0]           target_state,
    input  logic signed [31:0]   log_value,
    input  logic                 final_frame,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           path_state,
    output logic [5:0]           frame_index,
    output logic                 path_end,
    output logic                 frame_overflow
);
    import vpd_pkg::*;

    localparam int SCW = SCORE_WIDTH;
    localparam int EW = (SCW > 32) ? SCW : 32;
    localparam int SIW = $clog2(MAX_STATES);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int TAW = $clog2(MAX_STATES * MAX_STATES);
    localparam int BAW = $clog2(MAX_FRAMES * MAX_STATES);
    localparam int NS_CAP = (MAX_STATES < FIELD_STATES) ? MAX_STATES : FIELD_STATES;
    localparam logic signed [EW-1:0] SMAX = {{(EW - SCW + 1){1'b0}}, {(SCW - 1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = ~SMAX;

    function automatic logic signed [SCW-1:0] clamp_in(input logic signed [31:0] v);
        logic signed [EW-1:0] x;
        x = EW'(v);
        if (x > SMAX)
        begin
            return SCW'(SMAX);
        end
        if (x < SMIN)
        begin
            return SCW'(SMIN);
        end
        return SCW'(x);
    endfunction

    function automatic logic signed [SCW-1:0] sat_add(input logic signed [SCW-1:0] a,
                                                       input logic signed [SCW-1:0] b);
        logic [SCW:0] s;
        s = {a[SCW-1], a} + {b[SCW-1], b};
        if (s[SCW] != s[SCW-1])
        begin
            return s[SCW] ? {1'b1, {(SCW - 1){1'b0}}} : {1'b0, {(SCW - 1){1'b1}}};
        end
        return s[SCW-1:0];
    endfunction

    // configuration
    logic [4:0]         num_states_reg;
    logic signed [31:0] init_prior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= NUM_STATES_RESET;
            init_prior_reg <= INIT_PRIOR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_NUM_STATES: num_states_reg <= cfg_data[4:0];
                CFG_INIT_PRIOR: init_prior_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [4:0] ns;
    logic [4:0] ns_m1;
    always_comb
    begin
        priority if (num_states_reg == 5'd0)
        begin
            ns = 5'd1;
        end
        else if (int'(num_states_reg) > NS_CAP)
        begin
            ns = 5'(NS_CAP);
        end
        else
        begin
            ns = num_states_reg;
        end
        ns_m1 = ns - 5'd1;
    end

    // latched request
    logic                  cmd_q;
    logic [3:0]            src_q;
    logic [3:0]            tgt_q;
    logic signed [SCW-1:0] val_q;
    logic                  fin_q;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_q <= command;
            src_q <= source_state;
            tgt_q <= target_state;
            val_q <= clamp_in(log_value);
            fin_q <= final_frame;
        end
    end

    // control counters
    logic [FCW-1:0] fc_reg;
    logic           ovf_reg;
    logic [3:0]     k_reg;
    logic           pv_reg;
    logic [3:0]     pidx_reg;
    logic [3:0]     s_reg;
    logic [FW-1:0]  f_reg;

    // transition table
    logic signed [SCW-1:0] trans_mem [MAX_STATES * MAX_STATES];
    logic signed [SCW-1:0] trans_rd;
    logic [TAW-1:0]        trans_waddr;
    logic [TAW-1:0]        trans_raddr;

    assign trans_waddr = TAW'(src_q) * TAW'(MAX_STATES) + TAW'(tgt_q);
    assign trans_raddr = TAW'(k_reg) * TAW'(MAX_STATES) + TAW'(tgt_q);

    always_ff @(posedge clk)
    begin
        if (cmd.trans_wr && (int'(src_q) < MAX_STATES) && (int'(tgt_q) < MAX_STATES))
        begin
            trans_mem[trans_waddr] <= val_q;
        end
        trans_rd <= trans_mem[trans_raddr];
    end

    // backpointer memory
    logic [SIW-1:0] bp_mem [MAX_FRAMES * MAX_STATES];
    logic [SIW-1:0] bp_rd;
    logic [BAW-1:0] bp_waddr;
    logic [BAW-1:0] bp_raddr;
    logic [3:0]     bidx_reg;

    assign bp_waddr = BAW'(fc_reg) * BAW'(MAX_STATES) + BAW'(tgt_q);
    assign bp_raddr = BAW'(f_reg) * BAW'(MAX_STATES) + BAW'(s_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_scan)
        begin
            bp_mem[bp_waddr] <= SIW'(bidx_reg);
        end
        bp_rd <= bp_mem[bp_raddr];
    end

    // score banks
    logic signed [SCW-1:0] cur_reg  [MAX_STATES];
    logic signed [SCW-1:0] prev_reg [MAX_STATES];
    logic signed [SCW-1:0] score_q;
    logic signed [SCW-1:0] best_reg;
    logic signed [SCW-1:0] scan_sum;
    logic signed [SCW-1:0] prev_k;
    logic                  is_last;

    assign prev_k = prev_reg[SIW'(k_reg)];
    assign scan_sum = sat_add(score_q, trans_rd);
    assign is_last = ({1'b0, tgt_q} == ns_m1);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_first)
        begin
            cur_reg[SIW'(tgt_q)] <= sat_add(clamp_in(init_prior_reg), val_q);
        end
        else if (cmd.wr_scan)
        begin
            cur_reg[SIW'(tgt_q)] <= sat_add(best_reg, val_q);
        end
        if (cmd.close && is_last)
        begin
            prev_reg <= cur_reg;
        end
        if (cmd.scan_issue)
        begin
            score_q <= prev_k;
            pidx_reg <= k_reg;
        end
        // running maximum; lowest index wins a tie
        if (pv_reg)
        begin
            if ((pidx_reg == 4'd0) || (scan_sum > best_reg))
            begin
                best_reg <= scan_sum;
                bidx_reg <= pidx_reg;
            end
        end
        else if (cmd.am_step)
        begin
            if ((k_reg == 4'd0) || (prev_k > best_reg))
            begin
                best_reg <= prev_k;
                bidx_reg <= k_reg;
            end
        end
        if (cmd.seed)
        begin
            s_reg <= bidx_reg;
            f_reg <= FW'(fc_reg - FCW'(1));
        end
        else if (cmd.bt_next)
        begin
            s_reg <= 4'(bp_rd);
            f_reg <= f_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= '0;
            ovf_reg <= 1'b0;
            k_reg <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.scan_issue;
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.scan_issue || cmd.am_step)
            begin
                k_reg <= k_reg + 4'd1;
            end
            if (cmd.run_clear)
            begin
                fc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                if (cmd.close && is_last)
                begin
                    fc_reg <= fc_reg + FCW'(1);
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    logic out_valid_reg;
    logic [3:0] path_state_reg;
    logic [5:0] frame_index_reg;
    logic path_end_reg;
    logic frame_overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            path_state_reg <= s_reg;
            frame_index_reg <= 6'(f_reg);
            path_end_reg <= (f_reg == '0);
            frame_overflow_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign path_state = path_state_reg;
    assign frame_index = frame_index_reg;
    assign path_end = path_end_reg;
    assign frame_overflow = frame_overflow_reg;

    always_comb
    begin
        sts.is_trans = (cmd_q == CMD_TRANSITION);
        sts.in_range = ({1'b0, tgt_q} < ns);
        sts.frames_full = (int'(fc_reg) >= MAX_FRAMES);
        sts.first_frame = (fc_reg == '0);
        sts.k_last = ({1'b0, k_reg} == ns_m1);
        sts.decode_go = fin_q && is_last && (fc_reg != '0);
        sts.out_full = out_valid_reg;
        sts.f_zero = (f_reg == '0);
    end

endmodule

>>> rtl/core/viterbi_path_decoder.sv
// Viterbi path decoder top level: configuration port, sequencer and datapath.
// A transition write is taken and stored in the table. For a likelihood request, the max
// search reads one transition table entry per cycle over all source states. In frame
// zero there is no search, nor for an out-of-range target or once storage is full. The
// request for the last state of a final frame then adds the end-state search over all
// states and a backtrack with one backpointer memory read per emitted frame other than
// frame zero, waiting out any output stall. Input stays stalled throughout.
`include "viterbi_path_decoder_macros.svh"
module viterbi_path_decoder #(
    parameter int MAX_STATES  = 16,
    parameter int MAX_FRAMES  = 64,
    parameter int SCORE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [3:0]         source_state,
    input  logic [3:0]         target_state,
    input  logic signed [31:0] log_value,
    input  logic               final_frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         path_state,
    output logic [5:0]         frame_index,
    output logic               path_end,
    output logic               frame_overflow
);
    import vpd_pkg::*;

    vpd_cmd_t    cmd;
    vpd_status_t sts;

    assign cfg_ready = 1'b1;

    vpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vpd_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_FRAMES  (MAX_FRAMES),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .source_state   (source_state),
        .target_state   (target_state),
        .log_value      (log_value),
        .final_frame    (final_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .path_state     (path_state),
        .frame_index    (frame_index),
        .path_end       (path_end),
        .frame_overflow (frame_overflow)
    );

    // no new request is taken while a decoded state is pending
    `VPD_ASSERT_NOW(a_no_take_during_output, out_valid, in_stall)
    // an accepted request leaves the input stalled while the sequencer works on it
    `VPD_ASSERT_NEXT(a_request_holds_input, in_valid && !in_stall, in_stall)
    // the run's closing result always carries frame zero
    `VPD_ASSERT_NOW(a_end_is_frame_zero, out_valid && path_end, frame_index == 6'd0)

endmodule

>>> sim/vpd_checker.sv
// Path decoder checker: tracks accepted requests, predicts decoded paths, compares results.
`timescale 1ns / 1ps
module vpd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               command,
    input  logic [3:0]         source_state,
    input  logic [3:0]         target_state,
    input  logic signed [31:0] log_value,
    input  logic               final_frame,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         path_state,
    input  logic [5:0]         frame_index,
    input  logic               path_end,
    input  logic               frame_overflow,
    output int                 fail_count,
    output int                 pending
);
    import vpd_pkg::*;

    localparam longint SCORE_HI = 64'sd2147483647;
    localparam longint SCORE_LO = -64'sd2147483648;
    localparam int     FRAMES_MAX = 64;

    typedef struct packed {
        logic [3:0] state;
        logic [5:0] frame;
        logic       last;
        logic       ovf;
    } path_step_t;

    path_step_t  path_q[$];
    longint      trans_log[256];
    longint      prev_score[16];
    longint      cur_score[16];
    logic [3:0]  back_ptr[1024];
    int          frames_stored;
    bit          ovf_seen;
    logic [4:0]  states_reg;
    longint      prior_log;

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SCORE_HI) return SCORE_HI;
        if (s < SCORE_LO) return SCORE_LO;
        return s;
    endfunction

    function automatic int active_states();
        int n;
        n = states_reg;
        if (n < 1) n = 1;
        if (n > FIELD_STATES) n = FIELD_STATES;
        return n;
    endfunction

    task automatic trace_back(int ns);
        int s;
        longint best;
        path_step_t step;
        s = 0;
        best = prev_score[0];
        for (int k = 1; k < ns; k++)
        begin
            if (prev_score[k] > best)
            begin
                best = prev_score[k];
                s = k;
            end
        end
        for (int f = frames_stored - 1; f >= 0; f--)
        begin
            step.state = s[3:0];
            step.frame = f[5:0];
            step.last  = (f == 0);
            step.ovf   = ovf_seen;
            path_q.push_back(step);
            if (f > 0)
                s = back_ptr[f * 16 + s];
        end
        frames_stored = 0;
        ovf_seen = 0;
    endtask

    task automatic take_likelihood(int tgt, longint val, bit fin);
        int ns;
        int idx;
        longint best;
        longint v;
        ns = active_states();
        if (tgt >= ns)
            return;
        if (frames_stored < FRAMES_MAX)
        begin
            if (frames_stored == 0)
            begin
                cur_score[tgt] = sat_sum(prior_log, val);
                back_ptr[tgt] = tgt[3:0];
            end
            else
            begin
                idx = 0;
                best = sat_sum(prev_score[0], trans_log[tgt]);
                for (int k = 1; k < ns; k++)
                begin
                    v = sat_sum(prev_score[k], trans_log[k * 16 + tgt]);
                    if (v > best)
                    begin
                        best = v;
                        idx = k;
                    end
                end
                cur_score[tgt] = sat_sum(best, val);
                back_ptr[frames_stored * 16 + tgt] = idx[3:0];
            end
            if (tgt == ns - 1)
            begin
                prev_score = cur_score;
                frames_stored++;
            end
        end
        else
            ovf_seen = 1;
        if (fin && tgt == ns - 1 && frames_stored > 0)
            trace_back(ns);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        path_step_t want;
        if (!rst_n)
        begin
            path_q.delete();
            frames_stored = 0;
            ovf_seen = 0;
            states_reg = NUM_STATES_RESET;
            prior_log = INIT_PRIOR_RESET;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NUM_STATES)
                    states_reg = cfg_data[4:0];
                else
                    prior_log = longint'($signed(cfg_data));
            end
            if (out_valid && !out_stall)
            begin
                if (path_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected path result: state %0d frame %0d end %0b ovf %0b",
                                 path_state, frame_index, path_end, frame_overflow);
                end
                else
                begin
                    want = path_q.pop_front();
                    if (want.state !== path_state || want.frame !== frame_index ||
                        want.last !== path_end || want.ovf !== frame_overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"path mismatch: exp st %0d fr %0d end %0b ovf %0b, ",
                                      "got st %0d fr %0d end %0b ovf %0b"},
                                     want.state, want.frame, want.last, want.ovf,
                                     path_state, frame_index, path_end, frame_overflow);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_TRANSITION)
                    trans_log[source_state * 16 + target_state] = longint'(log_value);
                else
                    take_likelihood(target_state, longint'(log_value), final_frame);
            end
        end
        pending = path_q.size();
    end

endmodule

>>> sim/tb_top.sv
// Top-level testbench for the Viterbi path decoder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
    import vpd_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic               cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               command = 0;
    logic [3:0]         source_state = 0;
    logic [3:0]         target_state = 0;
    logic signed [31:0] log_value = 0;
    logic               final_frame = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [3:0]         path_state;
    logic [5:0]         frame_index;
    logic               path_end;
    logic               frame_overflow;
    int                 fail_count;
    int                 pending;

    int  n_items = 0;
    int  idle_cycles = 0;
    int  out_hold = 0;
    bit  calm = 0;
    int  cur_states = 16;

    always #5 clk = ~clk;

    viterbi_path_decoder u_top (.*);

    vpd_checker u_check (.*);

    // random stall on the result side, one draw per accepted result
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_stall = 1;
            out_hold--;
        end
        else
            out_stall = 0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_hold = calm ? 0 : $urandom_range(0, 3);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_log();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom_range(0, 3) << 16;    // small set, makes ties
            4: return -($urandom_range(0, 40) << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic cmd, logic [3:0] src, logic [3:0] tgt,
                                logic [31:0] val, logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        source_state = src;
        target_state = tgt;
        log_value = val;
        final_frame = fin;
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        n_items++;
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        in_valid = 0;
        wait (pending == 0);
        repeat (60) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
        if (idx == CFG_NUM_STATES)
            cur_states = (val[4:0] == 0) ? 1 : (val[4:0] > 16) ? 16 : val[4:0];
    endtask

    // well-formed frames, with noise mixed in when noisy is set; closes with a final frame
    task automatic run_frames(int n_frames, bit noisy);
        bit fin;
        for (int f = 0; f < n_frames; f++)
        begin
            for (int s = 0; s < cur_states; s++)
            begin
                if (noisy && $urandom_range(0, 5) == 0)
                begin
                    if (cur_states < 16 && $urandom_range(0, 1))
                        send_request(CMD_LIKELIHOOD, $urandom, $urandom_range(cur_states, 15),
                                     pick_log(), $urandom);
                    else
                        send_request(CMD_TRANSITION, $urandom, $urandom, pick_log(), $urandom);
                end
                if (s == cur_states - 1)
                    fin = (f == n_frames - 1);
                else
                    fin = $urandom;
                send_request(CMD_LIKELIHOOD, $urandom, s[3:0], pick_log(), fin);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // whole transition table first so no search reads an empty entry
        calm = 1;
        for (int i = 0; i < 256; i++)
            send_request(CMD_TRANSITION, i[7:4], i[3:0],
                         (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff : pick_log(),
                         i[0]);

        calm = 0;
        run_frames(2, 0);
        write_reg(CFG_NUM_STATES, 32'd0);
        write_reg(CFG_INIT_PRIOR, 32'h7fff_ffff);
        run_frames(3, 0);
        write_reg(CFG_NUM_STATES, 32'd31);
        write_reg(CFG_INIT_PRIOR, 32'h8000_0000);
        run_frames(1, 0);
        // more frames than storage holds
        write_reg(CFG_NUM_STATES, 32'd1);
        write_reg(CFG_INIT_PRIOR, 32'd0);
        run_frames(67, 1);

        while (n_items < 470)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(CFG_NUM_STATES, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 31) : $urandom_range(1, 5));
            if ($urandom_range(0, 1))
                write_reg(CFG_INIT_PRIOR, pick_log());
            run_frames($urandom_range(1, 8), 1);
        end

        in_valid = 0;
        wait (pending == 0);
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
